@@ rtl/core/sdad_pkg.sv @@
`timescale 1ns / 1ps
// Package for the soft disk alpha dilation block: FSM states, register map,
// control structs and arithmetic helpers. Depends on nothing.
package sdad_pkg;

  localparam int PADDR_W = 4;
  localparam int DIM_W   = 9;
  localparam int RAD_W   = 7;
  localparam int PIX_W   = 8;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;
  localparam logic [1:0] REG_ALPHA        = 2'd3;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd64;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd32;
  localparam logic [RAD_W-1:0] RST_RADIUS = 7'd32;
  localparam logic [PIX_W-1:0] RST_ALPHA  = 8'd255;

  localparam logic [63:0] ROOT_SCALE = 64'd16646400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_REDUCE,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        a_ge16;
    logic [15:0] a_sq;
    logic [15:0] am16_sq;
    logic [15:0] a255p8;
  } wcfg_t;

  typedef struct packed {
    logic shift;
    logic acc_en;
  } cell_ctl_t;

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    res = '0;
    rem = n;
    for (int i = 31; i >= 0; i--) begin
      bitv = 64'd1 << (2 * i);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

@@ rtl/core/sdad_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the coverage input and the alpha output.
// Depends on nothing.
interface sdad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coverage;
  modport source (output valid, output coverage, input ready);
  modport sink (input valid, input coverage, output ready);
endinterface

interface sdad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] outline_alpha_out;
  logic       frame_end;
  modport source (output valid, output outline_alpha_out, output frame_end, input ready);
  modport sink (input valid, input outline_alpha_out, input frame_end, output ready);
endinterface

@@ rtl/core/sdad_line_store.sv @@
`timescale 1ns / 1ps
// Line store: one coverage bank per disk row, written at the current pixel and
// read across all banks to give one masked window column. Uses sdad_pkg.
module sdad_line_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_REACH  = 8
) (
  input  logic                                        clk,
  input  logic                                        acc,
  input  logic [7:0]                                  cov,
  input  logic [$clog2(MAX_WIDTH+2*MAX_REACH)-1:0]    ox,
  input  logic [$clog2(MAX_HEIGHT+2*MAX_REACH)-1:0]   oy,
  input  logic [$clog2(2*MAX_REACH+1)-1:0]            bank,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]              w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]             h,
  output logic [2*MAX_REACH:0][7:0]                   col_out
);
  import sdad_pkg::*;

  localparam int SPAN = 2 * MAX_REACH + 1;
  localparam int LW   = $clog2(SPAN);
  localparam int AW   = $clog2(MAX_WIDTH);

  logic [7:0]      rd_r [SPAN];
  logic [SPAN-1:0] vld_r;
  logic [7:0]      cov_r;
  logic [LW-1:0]   bank_r;
  logic            we;
  logic [SPAN-1:0] vld_nxt;

  assign we = (32'(ox) < 32'(w)) && (32'(oy) < 32'(h));

  always_comb begin
    for (int l = 0; l < SPAN; l++) begin
      vld_nxt[l] = (32'(ox) < 32'(w)) && (l <= 32'(oy)) && (32'(oy) - l < 32'(h));
    end
  end

  for (genvar b = 0; b < SPAN; b++) begin : g_bank
    logic [7:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        if (we && bank == LW'(b)) begin
          mem[ox[AW-1:0]] <= cov;
        end
        rd_r[b] <= mem[ox[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      vld_r  <= vld_nxt;
      cov_r  <= cov;
      bank_r <= bank;
    end
  end

  always_comb begin
    for (int l = 0; l < SPAN; l++) begin
      int idx;
      idx = (32'(bank_r) >= l) ? 32'(bank_r) - l : 32'(bank_r) + SPAN - l;
      if (!vld_r[l]) begin
        col_out[l] = '0;
      end else if (l == 0) begin
        col_out[l] = cov_r;
      end else begin
        col_out[l] = rd_r[LW'(idx)];
      end
    end
  end

endmodule

@@ rtl/core/sdad_cell.sv @@
`timescale 1ns / 1ps
// One window column cell: holds a coverage column, shifts it to its neighbor,
// weights one tap per cycle and keeps a running maximum. Uses sdad_pkg.
module sdad_cell #(
  parameter int MAX_REACH = 8,
  parameter int CELL_IDX  = 0
) (
  input  logic                                  clk,
  input  sdad_pkg::cell_ctl_t                   ctl,
  input  sdad_pkg::wcfg_t                       wc,
  input  logic [$clog2(MAX_REACH+1)-1:0]        reach,
  input  logic [$clog2(2*MAX_REACH+1)-1:0]      lane,
  input  logic [$clog2(MAX_REACH+1)-1:0]        ady,
  input  logic [2*MAX_REACH:0][7:0]             col_in,
  output logic [2*MAX_REACH:0][7:0]             col_out,
  output logic [7:0]                            acc_out
);
  import sdad_pkg::*;

  localparam int RW   = $clog2(MAX_REACH + 1);
  localparam int SMAX = 2 * MAX_REACH * MAX_REACH;
  localparam int SW   = $clog2(SMAX + 1);
  localparam int QW   = $clog2(5771 * MAX_REACH + 1);

  logic [QW-1:0] qtab [SMAX+1];
  logic          exact_tab [SMAX+1];

  for (genvar g = 0; g <= SMAX; g++) begin : g_root
    localparam logic [63:0] TG = ROOT_SCALE * 64'(g);
    localparam logic [63:0] QG = root64(TG);
    assign qtab[g]      = QW'(QG);
    assign exact_tab[g] = (QG * QG == TG);
  end

  logic [2*MAX_REACH:0][7:0] col_r;
  logic [7:0]                w_r;
  logic [7:0]                cv_r;
  logic [15:0]               prod_r;
  logic [7:0]                acc_r;
  logic [7:0]                w_nxt;
  logic [7:0]                c_val;

  always_comb begin
    logic            active;
    int              dxi;
    logic [RW-1:0]   adx;
    logic [2*RW:0]   s_full;
    logic [SW-1:0]   s;
    logic [QW-1:0]   qv;
    logic [17:0]     qi;
    logic [17:0]     m;
    logic [13:0]     mq;
    active = CELL_IDX <= 2 * 32'(reach);
    dxi    = (CELL_IDX >= 32'(reach)) ? CELL_IDX - 32'(reach) : 32'(reach) - CELL_IDX;
    adx    = active ? RW'(dxi) : '0;
    s_full = (2*RW+1)'(adx) * (2*RW+1)'(adx) + (2*RW+1)'(ady) * (2*RW+1)'(ady);
    s      = SW'(s_full);
    qv     = qtab[s];
    qi     = 18'(qv) + 18'(!exact_tab[s]);
    m      = (18'(wc.a255p8) < qi) ? 18'd0 : 18'(wc.a255p8) - qi;
    mq     = m[17:4];
    if (!active || (32'({s, 8'd0}) >= 32'(wc.a_sq))) begin
      w_nxt = '0;
    end else if (wc.a_ge16 && (32'(wc.am16_sq) >= 32'({s, 8'd0}))) begin
      w_nxt = 8'd255;
    end else if (mq > 14'd255) begin
      w_nxt = 8'd255;
    end else begin
      w_nxt = mq[7:0];
    end
  end

  assign c_val = div255(prod_r + 16'd127);

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    cv_r   <= col_r[lane];
    prod_r <= 16'(cv_r) * 16'(w_r);
    if (ctl.shift) begin
      col_r <= col_in;
      acc_r <= '0;
    end else if (ctl.acc_en && c_val > acc_r) begin
      acc_r <= c_val;
    end
  end

  assign col_out = col_r;
  assign acc_out = acc_r;

endmodule

@@ rtl/core/soft_disk_alpha_dilation.sv @@
`timescale 1ns / 1ps
// Soft disk alpha dilation top level: register port, frame control, line store,
// cell chain and output stage. Uses sdad_pkg, sdad_if, sdad_line_store and sdad_cell.
//
// The block takes one coverage beat at a time and returns one outline alpha beat
// for it, in raster order over the padded frame of (W+2r) by (H+2r), r being
// the reach ceil(radius+0.5). The row of cells weighs the 2r+1 disk rows of a
// beat one disk row per cycle. A finished beat waits in the output register
// while the next beat is accepted. Registers take effect at the first beat of
// the next frame.
module soft_disk_alpha_dilation #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_REACH  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sdad_in_if.sink                        in_ch,
  sdad_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sdad_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import sdad_pkg::*;

  localparam int SPAN   = 2 * MAX_REACH + 1;
  localparam int LW     = $clog2(SPAN);
  localparam int RW     = $clog2(MAX_REACH + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CW     = $clog2(MAX_WIDTH + 2 * MAX_REACH);
  localparam int RCW    = $clog2(MAX_HEIGHT + 2 * MAX_REACH);
  localparam int RR_MAX = 16 * MAX_REACH - 9;
  localparam int P      = 1 << $clog2(SPAN);

  logic [DIM_W-1:0] cfg_w_r, cfg_h_r;
  logic [RAD_W-1:0] cfg_rad_r;
  logic [PIX_W-1:0] cfg_alpha_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= RST_WIDTH;
      cfg_h_r     <= RST_HEIGHT;
      cfg_rad_r   <= RST_RADIUS;
      cfg_alpha_r <= RST_ALPHA;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  cfg_w_r     <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_h_r     <= cfg_pwdata[DIM_W-1:0];
        REG_RADIUS:       cfg_rad_r   <= cfg_pwdata[RAD_W-1:0];
        REG_ALPHA:        cfg_alpha_r <= cfg_pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = 32'(cfg_w_r);
      REG_IMAGE_HEIGHT: cfg_prdata = 32'(cfg_h_r);
      REG_RADIUS:       cfg_prdata = 32'(cfg_rad_r);
      REG_ALPHA:        cfg_prdata = 32'(cfg_alpha_r);
      default:          cfg_prdata = '0;
    endcase
  end

  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_r;
  logic [RCW-1:0]  row_r;
  logic [LW-1:0]   bank_r;
  logic [LW-1:0]   lane_r;
  logic            pv0_r, pv1_r;
  logic            out_valid_r;
  logic [7:0]      out_alpha_r;
  logic            out_end_r;
  logic [WW-1:0]   cur_w;
  logic [HW-1:0]   cur_h;
  logic [RAD_W-1:0] cur_rr;
  logic [RW-1:0]   cur_r;
  logic [7:0]      cur_alpha;
  wcfg_t           wc_r;
  logic [7:0]      best_r;
  logic [15:0]     pa_r;

  logic            frame_start;
  logic [WW-1:0]   eff_w, use_w;
  logic [HW-1:0]   eff_h, use_h;
  logic [RAD_W-1:0] eff_rr;
  logic [RW-1:0]   eff_r;
  logic            acc_fire, fin_fire, running;
  logic            run_end;
  logic [RW-1:0]   ady;
  logic [CW:0]     ow;
  logic [RCW:0]    oh;
  logic            last_col, last_row;
  cell_ctl_t       ctl;

  assign frame_start = (col_r == '0) && (row_r == '0);
  assign eff_w  = (32'(cfg_w_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_r);
  assign eff_h  = (32'(cfg_h_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h_r);
  assign eff_rr = (32'(cfg_rad_r) > RR_MAX) ? RAD_W'(RR_MAX) : cfg_rad_r;
  assign eff_r  = RW'((32'(eff_rr) + 23) >> 4);
  assign use_w  = frame_start ? eff_w : cur_w;
  assign use_h  = frame_start ? eff_h : cur_h;

  assign run_end = (32'(lane_r) == 2 * 32'(cur_r));
  assign ady = (32'(lane_r) >= 32'(cur_r)) ? RW'(lane_r - LW'(cur_r)) : RW'(LW'(cur_r) - lane_r);
  assign ow  = (CW+1)'(cur_w) + (CW+1)'({cur_r, 1'b0});
  assign oh  = (RCW+1)'(cur_h) + (RCW+1)'({cur_r, 1'b0});
  assign last_col = ((CW+1)'(col_r) + (CW+1)'(1)) >= ow;
  assign last_row = ((RCW+1)'(row_r) + (RCW+1)'(1)) >= oh;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_RUN;
      ST_RUN:    if (run_end) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!pv0_r && !pv1_r) state_nxt = ST_REDUCE;
      ST_REDUCE: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_FIN;
      ST_FIN:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    acc_fire    = in_ch.valid && (state_r == ST_IDLE);
    running     = (state_r == ST_RUN);
    fin_fire    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
    ctl.shift   = (state_r == ST_LOAD);
    ctl.acc_en  = pv1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      bank_r      <= '0;
      lane_r      <= '0;
      pv0_r       <= 1'b0;
      pv1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv0_r   <= running;
      pv1_r   <= pv0_r;
      if (ctl.shift) begin
        lane_r <= '0;
      end else if (running) begin
        lane_r <= lane_r + LW'(1);
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
        if (last_col && last_row) begin
          col_r  <= '0;
          row_r  <= '0;
          bank_r <= '0;
        end else if (last_col) begin
          col_r  <= '0;
          row_r  <= row_r + RCW'(1);
          bank_r <= (bank_r == LW'(SPAN - 1)) ? '0 : bank_r + LW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic [7:0] cell_acc [SPAN];
  logic [7:0] tr [2*P];

  always_comb begin
    tr[0] = '0;
    for (int k = 0; k < P; k++) begin
      tr[P+k] = (k < SPAN) ? cell_acc[k] : 8'd0;
    end
    for (int k = P - 1; k >= 1; k--) begin
      tr[k] = (tr[2*k] > tr[2*k+1]) ? tr[2*k] : tr[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] a;
    logic [7:0] am16;
    a    = 8'(cur_rr) + 8'd8;
    am16 = a - 8'd16;
    if (acc_fire && frame_start) begin
      cur_w     <= eff_w;
      cur_h     <= eff_h;
      cur_rr    <= eff_rr;
      cur_r     <= eff_r;
      cur_alpha <= cfg_alpha_r;
    end
    wc_r.a_ge16  <= (a >= 8'd16);
    wc_r.a_sq    <= 16'(a) * 16'(a);
    wc_r.am16_sq <= 16'(am16) * 16'(am16);
    wc_r.a255p8  <= 16'(a) * 16'd255 + 16'd8;
    if (state_r == ST_REDUCE) begin
      best_r <= tr[1];
    end
    if (state_r == ST_MUL) begin
      pa_r <= 16'(best_r) * 16'(cur_alpha);
    end
    if (fin_fire) begin
      out_alpha_r <= div255(pa_r);
      out_end_r   <= last_col && last_row;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.outline_alpha_out = out_alpha_r;
  assign out_ch.frame_end         = out_end_r;

  logic [2*MAX_REACH:0][7:0] ls_col;
  logic [2*MAX_REACH:0][7:0] cell_col [SPAN];

  sdad_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_REACH  (MAX_REACH)
  ) u_line_store (
    .clk     (clk),
    .acc     (acc_fire),
    .cov     (in_ch.coverage),
    .ox      (col_r),
    .oy      (row_r),
    .bank    (bank_r),
    .w       (use_w),
    .h       (use_h),
    .col_out (ls_col)
  );

  for (genvar j = 0; j < SPAN; j++) begin : g_cell
    logic [2*MAX_REACH:0][7:0] col_in;
    if (j == 0) begin : g_head
      assign col_in = ls_col;
    end else begin : g_body
      assign col_in = (col_r == '0) ? '0 : cell_col[j-1];
    end
    sdad_cell #(
      .MAX_REACH (MAX_REACH),
      .CELL_IDX  (j)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wc      (wc_r),
      .reach   (cur_r),
      .lane    (lane_r),
      .ady     (ady),
      .col_in  (col_in),
      .col_out (cell_col[j]),
      .acc_out (cell_acc[j])
    );
  end

endmodule

@@ test/sdad_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the soft disk alpha dilation block: mirrors the register port,
// predicts each outline alpha beat and compares it. Uses sdad_pkg and sdad_if.
module sdad_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  sdad_in_if                           in_ch,
  sdad_out_if                          out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic                         cfg_pready,
  input  logic [sdad_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output int                           fail_count,
  output int                           pending
);
  import sdad_pkg::*;

  localparam int REACH = 8;
  localparam int SPAN  = 2 * REACH + 1;
  localparam int MAXW  = 256;
  localparam int MAXH  = 256;

  typedef struct packed {
    logic [7:0] alpha;
    logic       last;
  } alpha_beat_t;

  alpha_beat_t expected_alpha[$];

  logic [8:0] reg_width, reg_height;
  logic [6:0] reg_radius;
  logic [7:0] reg_alpha;
  int unsigned fr_w, fr_h, fr_r, fr_alpha;
  int unsigned col, row;
  logic [7:0] rows_mem[SPAN][MAXW];
  logic [7:0] wts[SPAN][SPAN];

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, bitv, rem;
    res = 0;
    rem = n;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] weight_byte(input longint a, input longint s);
    longint t, q, m;
    if (256 * s >= a * a) return 8'd0;
    if (a >= 16 && (a - 16) * (a - 16) >= 256 * s) return 8'd255;
    t = longint'(4080) * 4080 * s;
    q = longint'(isqrt(64'(t)));
    m = 255 * a + 8 - q;
    if (q * q != t) m = m - 1;
    if (m < 0) m = 0;
    m = m / 16;
    return (m > 255) ? 8'd255 : 8'(m);
  endfunction

  task automatic latch_frame();
    int unsigned rr;
    rr = (reg_radius > 119) ? 119 : reg_radius;
    fr_w = (reg_width > MAXW) ? MAXW : reg_width;
    fr_h = (reg_height > MAXH) ? MAXH : reg_height;
    fr_r = (rr + 23) >> 4;
    fr_alpha = reg_alpha;
    for (int dy = -REACH; dy <= REACH; dy++)
      for (int dx = -REACH; dx <= REACH; dx++)
        wts[dy + REACH][dx + REACH] = weight_byte(longint'(rr) + 8, dx * dx + dy * dy);
    for (int i = 0; i < SPAN; i++)
      for (int j = 0; j < MAXW; j++) rows_mem[i][j] = 8'd0;
  endtask

  task automatic predict_alpha(input logic [7:0] cov);
    int r, x, y;
    int unsigned ow, oh, best, c;
    alpha_beat_t b;
    if (col == 0 && row == 0) latch_frame();
    r = fr_r;
    ow = fr_w + 2 * fr_r;
    oh = fr_h + 2 * fr_r;
    if (col < fr_w && row < fr_h) rows_mem[row % SPAN][col] = cov;
    best = 0;
    for (int dy = -r; dy <= r; dy++) begin
      y = int'(row) - r - dy;
      if (y >= 0 && y < int'(fr_h)) begin
        for (int dx = -r; dx <= r; dx++) begin
          x = int'(col) - r - dx;
          if (x >= 0 && x < int'(fr_w)) begin
            c = (rows_mem[y % SPAN][x] * wts[dy + REACH][dx + REACH] + 127) / 255;
            if (c > best) best = c;
          end
        end
      end
    end
    b.alpha = 8'((best * fr_alpha) / 255);
    b.last = (col + 1 >= ow) && (row + 1 >= oh);
    expected_alpha = {expected_alpha, b};
    if (b.last) begin
      col = 0;
      row = 0;
    end else if (col + 1 >= ow) begin
      col = 0;
      row = row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    reg_width = RST_WIDTH;
    reg_height = RST_HEIGHT;
    reg_radius = RST_RADIUS;
    reg_alpha = RST_ALPHA;
    col = 0;
    row = 0;
  end

  always @(posedge clk) begin
    alpha_beat_t e;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_IMAGE_WIDTH: reg_width = cfg_pwdata[8:0];
          REG_IMAGE_HEIGHT: reg_height = cfg_pwdata[8:0];
          REG_RADIUS: reg_radius = cfg_pwdata[6:0];
          REG_ALPHA: reg_alpha = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_alpha(in_ch.coverage);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_alpha.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output beat %0d/%0b",
                                         out_ch.outline_alpha_out, out_ch.frame_end);
        end else begin
          e = expected_alpha.pop_front();
          if (e.alpha !== out_ch.outline_alpha_out || e.last !== out_ch.frame_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected alpha %0d end %0b, got alpha %0d end %0b",
                       e.alpha, e.last, out_ch.outline_alpha_out, out_ch.frame_end);
          end
        end
      end
      pending = expected_alpha.size();
    end
  end
endmodule

@@ test/tb_soft_disk_alpha_dilation.sv @@
`timescale 1ns / 1ps
// Top of the soft disk alpha dilation testbench: clock, reset, register writes,
// coverage frames and output stalls. Uses sdad_pkg, sdad_if and sdad_checker.
module tb_soft_disk_alpha_dilation;
  import sdad_pkg::*;

  localparam int LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending, cycles, sent_items;
  logic no_gaps;

  sdad_in_if in_ch();
  sdad_out_if out_ch();

  soft_disk_alpha_dilation dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sdad_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_soft_disk_alpha_dilation NOT OK");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls at random and, once, holds off for a long stretch.
  initial begin
    int hold, seen;
    logic pressed;
    hold = 0;
    seen = 0;
    pressed = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) seen++;
      if (!pressed && seen >= 120) begin
        pressed = 1;
        hold = 700;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (gap_len() > 0) begin
        hold = gap_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= PADDR_W'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] pick_coverage();
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sends one padded frame; a fixed value below 256 replaces the random coverage.
  task automatic run_frame(input int w, input int h, input int rad, input int alpha,
                           input int fixed_cov);
    int rr, r, n, g;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_ALPHA, alpha);
    rr = (rad > 119) ? 119 : rad;
    r = (rr + 23) >> 4;
    n = (((w > 256) ? 256 : w) + 2 * r) * (((h > 256) ? 256 : h) + 2 * r);
    sent_items += n;
    no_gaps = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      g = gap_len();
      if (g > 0) begin
        @(posedge clk);
        in_ch.valid <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
      @(posedge clk);
      in_ch.valid <= 1'b1;
      in_ch.coverage <= (fixed_cov < 256) ? 8'(fixed_cov) : pick_coverage();
      do @(posedge clk); while (!in_ch.ready);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int w, h;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.coverage <= 8'd0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    no_gaps = 0;
    sent_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    run_frame(1, 1, 0, 255, 255);
    run_frame(2, 2, 1, 0, 256);
    run_frame(511, 1, 1, 255, 256);
    run_frame(4, 3, 64, 255, 256);

    while (sent_items < 1650) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
      run_frame(w, h, $urandom_range(0, 127),
                ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                            : $urandom_range(0, 255), 256);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_soft_disk_alpha_dilation OK");
    end else begin
      $display("tb_soft_disk_alpha_dilation NOT OK");
    end
    $finish;
  end
endmodule
